[rtl/md5_message_digest_assert.svh]
// assertion macros shared by the md5 digest checker
`ifndef MD5_MESSAGE_DIGEST_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_ASSERT_SVH

// implication checked in the next cycle, quiet while reset is high
`define MD5_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("md5 digest check failed");

// implication checked in the next cycle, also across reset
`define MD5_ASSERT_RESET(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("md5 digest reset check failed");

`endif

[rtl/md5_pkg.sv]
// shared types, constants and round functions of the md5 digest block
package md5_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int BLOCK_BITS  = 512;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       no_byte;
    logic       last;
  } msg_t;

  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_low;
  } digest_t;

  // one 64-byte block handed from the front to the compression unit
  typedef struct packed {
    logic                  final_blk;
    logic [BLOCK_BITS-1:0] block;
  } job_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // message word used in a given round
  function automatic logic [3:0] word_index(logic [5:0] rnd);
    logic [3:0] r4;
    logic [3:0] idx;
    r4 = rnd[3:0];
    case (rnd[5:4])
      2'd0: idx = r4;
      2'd1: idx = (r4 << 2) + r4 + 4'd1;
      2'd2: idx = (r4 << 1) + r4 + 4'd5;
      default: idx = (r4 << 3) - r4;
    endcase
    return idx;
  endfunction

  // nonlinear mix of the four rounds groups
  function automatic logic [31:0] round_f(logic [1:0] stage, logic [31:0] b,
                                          logic [31:0] c, logic [31:0] d);
    logic [31:0] f;
    case (stage)
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rol32(logic [31:0] x, logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

endpackage

[rtl/md5_queue.sv]
// short block queue between the byte front and the compression unit
module md5_queue #(
  parameter int Depth = md5_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  md5_pkg::job_t push_job,
  output logic          full,
  output logic          empty,
  input  logic          pop,
  output md5_pkg::job_t head_job
);
  import md5_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  job_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntW'(Depth));
  assign empty    = (count == '0);
  assign head_job = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/md5_front.sv]
// byte packer and padding generator feeding the block queue
module md5_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          msg_valid,
  output logic          msg_ready,
  input  md5_pkg::msg_t msg,
  output logic          push,
  output md5_pkg::job_t push_job,
  input  logic          full
);
  import md5_pkg::*;

  localparam logic [1:0] ST_TAKE = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;

  logic [1:0]            state;
  logic [BLOCK_BITS-1:0] blk_buf;
  logic [60:0]           byte_count;

  logic [5:0]            pos;
  logic                  take;
  logic [BLOCK_BITS-1:0] filled;
  logic [BLOCK_BITS-1:0] padded;
  logic [63:0]           bit_len;
  logic                  fits_len;

  assign pos       = byte_count[5:0];
  assign take      = msg_valid && msg_ready;
  assign bit_len   = {byte_count, 3'b000};
  assign fits_len  = (pos < LEN_POS);
  assign msg_ready = (state == ST_TAKE) && !full;

  // buffer with the incoming byte dropped in place
  always_comb begin
    filled = blk_buf;
    filled[{pos, 3'b000} +: 8] = msg.data_byte;
  end

  // terminator, zero fill and, when it fits, the bit length
  always_comb begin
    padded = '0;
    for (int i = 0; i < 64; i++) begin
      if (6'(i) < pos) begin
        padded[i*8 +: 8] = blk_buf[i*8 +: 8];
      end else if (6'(i) == pos) begin
        padded[i*8 +: 8] = PAD_BYTE;
      end
    end
    if (fits_len) begin
      padded[BLOCK_BITS-64 +: 64] = bit_len;
    end
  end

  // block beats toward the queue
  always_comb begin
    push     = 1'b0;
    push_job = '{final_blk: 1'b0, block: filled};
    case (state)
      ST_TAKE: begin
        push = take && !msg.no_byte && (pos == LAST_POS);
      end
      ST_PAD: begin
        push     = !full;
        push_job = '{final_blk: fits_len, block: padded};
      end
      ST_LEN: begin
        push     = !full;
        push_job = '{final_blk: 1'b1, block: {bit_len, {(BLOCK_BITS-64){1'b0}}}};
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // byte buffer, count and message-end sequence
  always_ff @(posedge clk) begin
    if (state == ST_TAKE && take && !msg.no_byte) begin
      blk_buf <= filled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_TAKE;
      byte_count <= '0;
    end else begin
      case (state)
        ST_TAKE: begin
          if (take) begin
            if (!msg.no_byte) begin
              byte_count <= byte_count + 1'b1;
            end
            if (msg.last) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (!full) begin
            if (fits_len) begin
              byte_count <= '0;
              state      <= ST_TAKE;
            end else begin
              state <= ST_LEN;
            end
          end
        end
        ST_LEN: begin
          if (!full) begin
            byte_count <= '0;
            state      <= ST_TAKE;
          end
        end
        default: begin
          state <= ST_TAKE;
        end
      endcase
    end
  end

endmodule

[rtl/md5_back.sv]
// md5 compression unit, one round per cycle, with the digest output register
module md5_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  md5_pkg::job_t    head_job,
  output logic             pop,
  output logic             digest_valid,
  input  logic             digest_ready,
  output md5_pkg::digest_t digest
);
  import md5_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_SUM   = 2'd2;

  logic [1:0]  state;
  logic [5:0]  rnd;
  logic [31:0] a, b, c, d;
  logic [31:0] ch_a, ch_b, ch_c, ch_d;

  logic [1:0]  stage;
  logic [31:0] f;
  logic [31:0] w;
  logic [31:0] mix;
  logic [31:0] b_next;
  logic [31:0] sum_a, sum_b, sum_c, sum_d;
  logic        out_free;

  // one round of the working state
  assign stage  = rnd[5:4];
  assign f      = round_f(stage, b, c, d);
  assign w      = head_job.block[{word_index(rnd), 5'b00000} +: 32];
  assign mix    = a + f + ROUND_K[rnd] + w;
  assign b_next = b + rol32(mix, ROT_AMT[{stage, rnd[1:0]}]);

  // chaining update after the last round
  assign sum_a    = ch_a + a;
  assign sum_b    = ch_b + b;
  assign sum_c    = ch_c + c;
  assign sum_d    = ch_d + d;
  assign out_free = !digest_valid || digest_ready;
  assign pop      = (state == ST_SUM) && (!head_job.final_blk || out_free);

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        a <= ch_a;
        b <= ch_b;
        c <= ch_c;
        d <= ch_d;
      end
      ST_ROUND: begin
        a <= d;
        d <= c;
        c <= b;
        b <= b_next;
      end
      default: begin
        a <= a;
      end
    endcase
  end

  // digest payload
  always_ff @(posedge clk) begin
    if (pop && head_job.final_blk) begin
      digest <= '{digest_high: {sum_d, sum_c}, digest_low: {sum_b, sum_a}};
    end
  end

  // sequencer, chaining words and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rnd          <= '0;
      ch_a         <= INIT_A;
      ch_b         <= INIT_B;
      ch_c         <= INIT_C;
      ch_d         <= INIT_D;
      digest_valid <= 1'b0;
    end else begin
      // output beat loaded by a finished message, dropped once taken
      if (pop && head_job.final_blk) begin
        digest_valid <= 1'b1;
      end else if (digest_ready) begin
        digest_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            rnd   <= '0;
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          rnd <= rnd + 1'b1;
          if (rnd == LAST_POS) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (pop) begin
            state <= ST_IDLE;
            if (head_job.final_blk) begin
              ch_a <= INIT_A;
              ch_b <= INIT_B;
              ch_c <= INIT_C;
              ch_d <= INIT_D;
            end else begin
              ch_a <= sum_a;
              ch_b <= sum_b;
              ch_c <= sum_c;
              ch_d <= sum_d;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/md5_message_digest.sv]
// top level of the md5 digest block: byte front, block queue, compression unit
// Takes one message byte per beat on msg and returns the 128-bit md5 digest on
// digest after the beat marked last. The front accepts a byte every cycle while
// it is not padding and the block queue (QueueDepth blocks, two by default) has
// room; each 64-byte block then passes through the compression unit as one load
// step, 64 rounds at one round per cycle and one chaining-sum step, and the unit
// takes the next block from the queue only after that sum. After the last beat
// the front builds one padding block, or two when fewer than nine bytes are left
// in the block, and the digest is registered once the final block's chaining sum
// is done. The digest sits in an output register until taken; only a second
// digest waiting behind it stalls the compression unit.
module md5_message_digest #(
  parameter int QueueDepth = md5_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             msg_valid,
  output logic             msg_ready,
  input  md5_pkg::msg_t    msg,
  output logic             digest_valid,
  input  logic             digest_ready,
  output md5_pkg::digest_t digest
);
  import md5_pkg::*;

  logic push;
  logic full;
  logic empty;
  logic pop;
  job_t push_job;
  job_t head_job;

  // byte packing and padding
  md5_front u_front (
    .clk      (clk),
    .rst      (rst),
    .msg_valid(msg_valid),
    .msg_ready(msg_ready),
    .msg      (msg),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  // block queue
  md5_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .head_job(head_job)
  );

  // compression and digest output
  md5_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .head_job    (head_job),
    .pop         (pop),
    .digest_valid(digest_valid),
    .digest_ready(digest_ready),
    .digest      (digest)
  );

endmodule

[rtl/md5_message_digest_checker.sv]
// port-level checker for the md5 digest block and its bind
`include "md5_message_digest_assert.svh"

module md5_message_digest_checker (
  input logic             clk,
  input logic             rst,
  input logic             msg_valid,
  input logic             msg_ready,
  input md5_pkg::msg_t    msg,
  input logic             digest_valid,
  input logic             digest_ready,
  input md5_pkg::digest_t digest
);

  // a waiting digest beat stays offered
  `MD5_ASSERT_NEXT(a_digest_hold, digest_valid && !digest_ready, digest_valid)

  // a waiting digest beat keeps its value
  `MD5_ASSERT_NEXT(a_digest_stable, digest_valid && !digest_ready, $stable(digest))

  // the end of a message closes the input while padding goes out
  `MD5_ASSERT_NEXT(a_last_closes, msg_valid && msg_ready && msg.last, !msg_ready)

  // reset leaves no digest pending and the input open
  `MD5_ASSERT_RESET(a_reset_state, rst, !digest_valid && msg_ready)

endmodule

bind md5_message_digest md5_message_digest_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .msg_valid   (msg_valid),
  .msg_ready   (msg_ready),
  .msg         (msg),
  .digest_valid(digest_valid),
  .digest_ready(digest_ready),
  .digest      (digest)
);
